// ===== rtl/cbpp_pkg.sv =====
// Shared types, constants and helpers for the cubic Bezier ping-pong path block.
// No dependencies; imported by every module of the block.
package cbpp_pkg;

    localparam int COORD_WIDTH    = 16;   // signed Q8.8 coordinate
    localparam int TIME_FRAC_BITS = 12;   // fraction bits of the query time
    localparam int TIME_W         = 32;
    localparam int PT_W           = 3 * COORD_WIDTH;
    localparam int CFG_IDX_W      = 3;

    // t and u live in 0..65536 (Q0.16 with room for 1.0)
    localparam int T_FRAC = 16;
    localparam int T_W    = T_FRAC + 1;

    // t^2, u^2 and the blend weights, all up to 2^32
    localparam int SQ_W = 2 * T_FRAC + 1;

    // shared multiplier: A holds t, u, squares or weights, B holds t, u or a coordinate
    localparam int MA_W   = SQ_W + 1;
    localparam int MB_W   = ((COORD_WIDTH > T_W) ? COORD_WIDTH : T_W) + 1;
    localparam int PROD_W = MA_W + MB_W;

    localparam int ACC_SHIFT = 2 * T_FRAC;   // Q.40 -> Q8.8
    localparam int DIV_CNT_W = 5;

    localparam logic [TIME_W-1:0] TIME_ONE  = TIME_W'(1) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] END_RESET = TIME_W'(4096);
    localparam logic [T_W-1:0]    T_ONE     = T_W'(1) << T_FRAC;

    localparam logic signed [PROD_W-1:0] ACC_RND = PROD_W'(1) <<< (ACC_SHIFT - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CP0   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CP1   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CP2   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CP3   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_START = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_END   = CFG_IDX_W'(5);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic issue;       // capture a*b into the product register
        logic acc_first;   // acc <= product + rounding bias
        logic acc_next;    // acc <= acc + product
    } cbpp_mac_ctrl_t;

    function automatic logic signed [COORD_WIDTH-1:0] coord_of(
        input logic [PT_W-1:0] p,
        input logic [1:0]      axis
    );
        logic signed [COORD_WIDTH-1:0] c;
        case (axis)
            AXIS_X:  c = p[0 +: COORD_WIDTH];
            AXIS_Y:  c = p[COORD_WIDTH +: COORD_WIDTH];
            AXIS_Z:  c = p[2*COORD_WIDTH +: COORD_WIDTH];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/cbpp_div.sv =====
// Restoring divider for the curve parameter: quot = floor(num * 2^16 / den), num <= den.
// One quotient bit per cycle. Depends on cbpp_pkg.
module cbpp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cbpp_pkg::TIME_W-1:0]  num,
    input  logic [cbpp_pkg::TIME_W-1:0]  den,
    output logic                         done,
    output logic [cbpp_pkg::T_W-1:0]     quot
);
    import cbpp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_W:0]      rem_reg;
    logic [TIME_W-1:0]    den_reg;
    logic [T_W-1:0]       q_reg;

    logic [TIME_W:0]      trial;
    logic [TIME_W+1:0]    diff;
    logic                 fits;

    // first step tests num >= den (t = 1.0), the rest shift in zeros
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[TIME_W-1:0], 1'b0};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[TIME_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? diff[TIME_W:0] : trial;
                q_reg   <= {q_reg[T_W-2:0], fits};
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(T_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/cbpp_mac.sv =====
// Shared signed multiplier with registered product and a blend accumulator.
// Depends on cbpp_pkg.
module cbpp_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cbpp_pkg::cbpp_mac_ctrl_t            ctrl,
    input  logic signed [cbpp_pkg::MA_W-1:0]    a,
    input  logic signed [cbpp_pkg::MB_W-1:0]    b,
    output logic signed [cbpp_pkg::PROD_W-1:0]  prod,
    output logic signed [cbpp_pkg::PROD_W-1:0]  sum
);
    import cbpp_pkg::*;

    logic signed [PROD_W-1:0] mul_full;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;

    assign mul_full = a * b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctrl.issue)
                prod_reg <= mul_full;
            if (ctrl.acc_first)
                acc_reg <= prod_reg + ACC_RND;
            else if (ctrl.acc_next)
                acc_reg <= sum;
        end
    end

    assign prod = prod_reg;
    assign sum  = acc_reg + prod_reg;

endmodule

// ===== rtl/cubic_bezier_pingpong_path.sv =====
// Top level: cubic Bezier position along a back-and-forth path over a time window.
// Depends on cbpp_pkg, cbpp_div and cbpp_mac.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in       | in_valid  / in_ready  | current_time (Q20.12)
//   out      | out_valid / out_ready | pos_x, pos_y, pos_z (Q8.8), turned
//
// A time outside the window is classified, loaded into the output register and
// then given as the output beat. A time inside is classified, goes through 17
// divider steps and the taking of the quotient (both skipped for a zero-length
// window), 19 steps of the shared multiplier, the load of the output register
// and the beat. The shared multiplier forms six products for the weights and
// twelve for the blend, one product each cycle with the previous one being consumed.
// in_ready is high only while idle; the output register lets a new beat be
// accepted while the previous result still waits, and the block then stalls
// in its final state until out_ready frees the register.
// Reset loads the pass window from the reset values of start_time/end_time.
// cfg_ready is always high; writes are expected only while the block is idle.
module cubic_bezier_pingpong_path (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cbpp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [cbpp_pkg::PT_W-1:0]               cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [cbpp_pkg::TIME_W-1:0]             current_time,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_x,
    output logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_y,
    output logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_z,
    output logic                                    turned
);
    import cbpp_pkg::*;

    localparam int RS_W = PROD_W - ACC_SHIFT;

    // multiplier schedule; consume of step k happens during step k+1
    localparam logic [4:0] STEP_UU    = 5'd0;
    localparam logic [4:0] STEP_TT    = 5'd1;
    localparam logic [4:0] STEP_TUU   = 5'd2;
    localparam logic [4:0] STEP_TTU   = 5'd3;
    localparam logic [4:0] STEP_UUU   = 5'd4;
    localparam logic [4:0] STEP_TTT   = 5'd5;
    localparam logic [4:0] STEP_BLEND = 5'd6;   // 12 blend products: axis-major
    localparam logic [4:0] STEP_LAST  = 5'd18;  // consume only

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_DIV,
        S_MUL,
        S_FIN
    } state_t;

    state_t               state_reg;

    // configuration and pass window
    logic [PT_W-1:0]      cp_reg [4];
    logic [TIME_W-1:0]    start_reg;
    logic [TIME_W-1:0]    end_reg;
    logic [TIME_W-1:0]    ps_reg;
    logic [TIME_W-1:0]    pe_reg;
    logic [TIME_W-1:0]    len_reg;
    logic                 rev_reg;

    // working registers
    logic [TIME_W-1:0]    now_reg;
    logic [T_W-1:0]       t_reg;
    logic [SQ_W-1:0]      uu_reg;
    logic [SQ_W-1:0]      tt_reg;
    logic [SQ_W-1:0]      w_reg [4];
    logic [4:0]           step_reg;
    logic signed [COORD_WIDTH-1:0] res_reg [3];
    logic                 res_turn_reg;

    // output register
    logic                 out_valid_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg [3];
    logic                 turned_reg;

    logic [T_W-1:0]       u_val;
    logic [4:0]           cons_op;
    logic [4:0]           bj;
    logic [4:0]           cj;
    logic [1:0]           pt_sel;
    logic signed [COORD_WIDTH-1:0] coord_sel;
    logic [PT_W-1:0]      p_first;
    logic [PT_W-1:0]      p_last;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    logic [PROD_W-1:0]        prod_u;
    logic [PROD_W+1:0]        w1x_sum;
    logic [PROD_W+1:0]        w3x_sum;
    logic [SQ_W-1:0]          w1x_val;
    logic [SQ_W-1:0]          w3x_val;
    logic signed [RS_W-1:0]   rs;
    logic signed [COORD_WIDTH-1:0] sat_val;
    cbpp_mac_ctrl_t           mac_ctrl;

    logic                 below;
    logic                 above;
    logic                 div_start;
    logic                 div_done;
    logic [T_W-1:0]       div_quot;
    logic                 fin_load;

    assign u_val   = T_ONE - t_reg;
    assign cons_op = step_reg - 5'd1;
    assign bj      = step_reg - STEP_BLEND;
    assign cj      = cons_op - STEP_BLEND;

    // reversed pass reads the points back to front
    assign pt_sel    = rev_reg ? ~bj[1:0] : bj[1:0];
    assign coord_sel = coord_of(cp_reg[pt_sel], bj[3:2]);
    assign p_first   = rev_reg ? cp_reg[3] : cp_reg[0];
    assign p_last    = rev_reg ? cp_reg[0] : cp_reg[3];

    assign below     = now_reg < ps_reg;
    assign above     = now_reg > pe_reg;
    assign div_start = (state_reg == S_CLASS) && !below && !above && (len_reg != '0);

    // result moves into the output register once that register is free
    assign fin_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STEP_UU:
            begin
                mul_a = MA_W'(u_val);
                mul_b = MB_W'(u_val);
            end
            STEP_TT:
            begin
                mul_a = MA_W'(t_reg);
                mul_b = MB_W'(t_reg);
            end
            STEP_TUU:
            begin
                mul_a = MA_W'(uu_reg);
                mul_b = MB_W'(t_reg);
            end
            STEP_TTU:
            begin
                mul_a = MA_W'(tt_reg);
                mul_b = MB_W'(u_val);
            end
            STEP_UUU:
            begin
                mul_a = MA_W'(uu_reg);
                mul_b = MB_W'(u_val);
            end
            STEP_TTT:
            begin
                mul_a = MA_W'(tt_reg);
                mul_b = MB_W'(t_reg);
            end
            default:
            begin
                mul_a = MA_W'(w_reg[bj[1:0]]);
                mul_b = MB_W'(coord_sel);   // sign-extends
            end
        endcase
    end

    always_comb
    begin
        mac_ctrl.issue     = (state_reg == S_MUL) && (step_reg < STEP_LAST);
        mac_ctrl.acc_first = (state_reg == S_MUL) && (step_reg > STEP_BLEND)
                             && (cj[1:0] == 2'd0);
        mac_ctrl.acc_next  = (state_reg == S_MUL) && (step_reg > STEP_BLEND)
                             && (cj[1:0] != 2'd0);
    end

    // weight rounding: (p + 2^15) >> 16 and (3p + 2^15) >> 16
    assign prod_u  = unsigned'(prod);
    assign w1x_sum = (PROD_W+2)'(prod_u) + (PROD_W+2)'(T_ONE >> 1);
    assign w3x_sum = ((PROD_W+2)'(prod_u) << 1) + (PROD_W+2)'(prod_u)
                     + (PROD_W+2)'(T_ONE >> 1);
    assign w1x_val = w1x_sum[T_FRAC +: SQ_W];
    assign w3x_val = w3x_sum[T_FRAC +: SQ_W];

    // final coordinate: bias already in the accumulator, floor shift, saturate
    assign rs = sum[PROD_W-1:ACC_SHIFT];

    always_comb
    begin
        if (!rs[RS_W-1] && (|rs[RS_W-2:COORD_WIDTH-1]))
            sat_val = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        else if (rs[RS_W-1] && !(&rs[RS_W-2:COORD_WIDTH-1]))
            sat_val = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        else
            sat_val = rs[COORD_WIDTH-1:0];
    end

    cbpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (now_reg - ps_reg),
        .den   (len_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    cbpp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (prod),
        .sum   (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cp_reg        <= '{default: '0};
            start_reg     <= '0;
            end_reg       <= END_RESET;
            ps_reg        <= '0;
            pe_reg        <= END_RESET;
            len_reg       <= END_RESET;
            rev_reg       <= 1'b0;
            now_reg       <= '0;
            t_reg         <= '0;
            uu_reg        <= '0;
            tt_reg        <= '0;
            w_reg         <= '{default: '0};
            step_reg      <= '0;
            res_reg       <= '{default: '0};
            res_turn_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '{default: '0};
            turned_reg    <= 1'b0;
        end
        else
        begin
            // configuration; a time write reloads the window in forward order
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CP0, REG_CP1, REG_CP2, REG_CP3:
                        cp_reg[cfg_index[1:0]] <= cfg_data;
                    REG_START:
                    begin
                        start_reg <= cfg_data[TIME_W-1:0];
                        ps_reg    <= cfg_data[TIME_W-1:0];
                        pe_reg    <= end_reg;
                        len_reg   <= end_reg - cfg_data[TIME_W-1:0];
                        rev_reg   <= 1'b0;
                    end
                    REG_END:
                    begin
                        end_reg   <= cfg_data[TIME_W-1:0];
                        ps_reg    <= start_reg;
                        pe_reg    <= cfg_data[TIME_W-1:0];
                        len_reg   <= cfg_data[TIME_W-1:0] - start_reg;
                        rev_reg   <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        now_reg   <= current_time;
                        state_reg <= S_CLASS;
                    end
                end

                S_CLASS:
                begin
                    res_turn_reg <= 1'b0;
                    if (below)
                    begin
                        res_reg[0] <= coord_of(p_first, AXIS_X);
                        res_reg[1] <= coord_of(p_first, AXIS_Y);
                        res_reg[2] <= coord_of(p_first, AXIS_Z);
                        state_reg  <= S_FIN;
                    end
                    else if (above)
                    begin
                        // end of pass: emit last point, flip order, slide window
                        res_reg[0]   <= coord_of(p_last, AXIS_X);
                        res_reg[1]   <= coord_of(p_last, AXIS_Y);
                        res_reg[2]   <= coord_of(p_last, AXIS_Z);
                        res_turn_reg <= 1'b1;
                        rev_reg      <= ~rev_reg;
                        ps_reg       <= pe_reg + TIME_ONE;
                        pe_reg       <= pe_reg + TIME_ONE + len_reg;
                        state_reg    <= S_FIN;
                    end
                    else if (len_reg == '0)
                    begin
                        t_reg     <= T_ONE;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        t_reg     <= div_quot;
                        step_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    step_reg <= step_reg + 5'd1;
                    if (step_reg != '0)
                    begin
                        case (cons_op)
                            STEP_UU:  uu_reg   <= prod_u[SQ_W-1:0];
                            STEP_TT:  tt_reg   <= prod_u[SQ_W-1:0];
                            STEP_TUU: w_reg[1] <= w3x_val;
                            STEP_TTU: w_reg[2] <= w3x_val;
                            STEP_UUU: w_reg[0] <= w1x_val;
                            STEP_TTT: w_reg[3] <= w1x_val;
                            default:
                            begin
                                if (cj[1:0] == 2'd3)
                                    res_reg[cj[3:2]] <= sat_val;
                            end
                        endcase
                    end
                    if (step_reg == STEP_LAST)
                        state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    if (fin_load)
                    begin
                        pos_reg       <= res_reg;
                        turned_reg    <= res_turn_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];
    assign turned    = turned_reg;

endmodule

// ===== rtl/cbpp_check.sv =====
// Port-level checker for cubic_bezier_pingpong_path, attached by bind.
// Depends on cbpp_pkg.
module cbpp_check (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic                                    in_ready,
    input  logic                                    out_valid,
    input  logic                                    out_ready,
    input  logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_x,
    input  logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_y,
    input  logic signed [cbpp_pkg::COORD_WIDTH-1:0] pos_z,
    input  logic                                    turned
);
    import cbpp_pkg::*;

    logic [1:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // beats accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_beat && !out_beat)
            pending_reg <= pending_reg + 2'd1;
        else if (out_beat && !in_beat)
            pending_reg <= pending_reg - 2'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
                                    && $stable(pos_z) && $stable(turned))
        else $error("output beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("input taken again while an item is in work");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (pending_reg == 2'd0 || pending_reg == 2'd1))
        else $error("ready with two items already outstanding");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("output beat with no item outstanding");

endmodule

bind cubic_bezier_pingpong_path cbpp_check u_cbpp_check (.*);
